// ----- rtl/core/micc_pkg.sv -----
// ----------------------------------------------------------------------------
// Chain counter package
// Shared sizes for the increasing-chain counter and its table memory.
// ----------------------------------------------------------------------------
package micc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_BITS  = 30;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_W     = 11;
  localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((COUNT_W + 7) / 8) * 8;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;

endpackage

// ----- rtl/core/micc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module micc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/min_increasing_chain_counter.sv -----
// ----------------------------------------------------------------------------
// Minimum increasing chain counter
// Patience-sorting table of chain tops searched by a shared binary search.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata                     tuser
//  s_axis   in         sample_value [29:0]       start_new
//  m_axis   out        chain_count  [10:0]       overflow
//
// Each item is accepted, then searched by binary-search probes, and ends with a
// final range check and the table update; each probe is one read of the table
// RAM's single read port followed by one compare.
// Reset empties the table at once through the chain total; no clearing pass.
// A result held in the output register stalls only the final table update.
module min_increasing_chain_counter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [micc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // sample_value
  input  logic                               s_axis_tuser,  // start_new
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [micc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // chain_count
  output logic                               m_axis_tuser   // overflow
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_UPDATE
  } state_e;

  state_e           state_q, state_d;
  micc_pkg::value_t value_q, value_d;
  micc_pkg::cnt_t   total_q, total_d;
  micc_pkg::cnt_t   lo_q, lo_d;
  micc_pkg::cnt_t   hi_q, hi_d;
  micc_pkg::cnt_t   mid;
  logic             out_valid_q, out_valid_d;
  micc_pkg::cnt_t   out_count_q, out_count_d;
  logic             out_ovf_q, out_ovf_d;
  logic             ram_we;
  micc_pkg::value_t ram_rdata;
  logic             in_xfer;
  logic [31:0]      count_wide;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign mid           = lo_q + ((hi_q - lo_q) >> 1);

  micc_ram #(
    .WIDTH (micc_pkg::VALUE_BITS),
    .DEPTH (micc_pkg::TABLE_DEPTH)
  ) u_tops (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lo_q[micc_pkg::ADDR_W-1:0]),
    .wdata_i (value_q),
    .raddr_i (mid[micc_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    total_d     = total_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          value_d = s_axis_tdata[micc_pkg::VALUE_BITS-1:0];
          total_d = s_axis_tuser ? '0 : total_q;
          lo_d    = '0;
          hi_d    = s_axis_tuser ? '0 : total_q;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = (lo_q < hi_q) ? ST_CMP : ST_UPDATE;
      end
      ST_CMP: begin
        if (ram_rdata < value_q) begin
          hi_d = mid;
        end else begin
          lo_d = mid + micc_pkg::cnt_t'(1);
        end
        state_d = ST_READ;
      end
      ST_UPDATE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_ovf_d   = 1'b0;
          out_count_d = total_q;
          if (lo_q < total_q) begin
            ram_we = 1'b1;
          end else if (total_q < micc_pkg::cnt_t'(micc_pkg::TABLE_DEPTH)) begin
            ram_we      = 1'b1;
            total_d     = total_q + micc_pkg::cnt_t'(1);
            out_count_d = total_d;
          end else begin
            out_ovf_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      value_q     <= '0;
      total_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      value_q     <= value_d;
      total_q     <= total_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
      out_count_q <= out_count_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign count_wide    = 32'(out_count_q);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ovf_q;
  assign m_axis_tdata  = micc_pkg::OUT_TDATA_W'(count_wide[micc_pkg::COUNT_W-1:0]);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_count_q <= micc_pkg::cnt_t'(micc_pkg::TABLE_DEPTH))
    else $error("chain count above table depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser)
      |-> out_count_q == micc_pkg::cnt_t'(micc_pkg::TABLE_DEPTH))
    else $error("overflow reported with a table that is not full");

  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_CMP || state_q == ST_UPDATE)
      |-> (lo_q <= hi_q && hi_q <= total_q))
    else $error("binary search range out of order");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a search is under way");

endmodule
